@@ sv/limit_order_matcher_unit_macros.svh @@
// Assertion macros for the limit order matcher.
// Included by the top level only; no dependencies.
`ifndef LIMIT_ORDER_MATCHER_UNIT_MACROS_SVH
`define LIMIT_ORDER_MATCHER_UNIT_MACROS_SVH
// Assert an implication on the next cycle, gated by reset.
`define LOM_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);
// Assert an implication in the same cycle, gated by reset.
`define LOM_ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);
`endif

@@ sv/lom_pkg.sv @@
// Shared constants and controller/datapath interface types for the matcher.
// No dependencies.
package lom_pkg;
    localparam int ORDERS_PER_SIDE = 32;
    localparam int PRICE_BITS      = 16;
    localparam int SLOTS           = 2 * ORDERS_PER_SIDE;
    localparam int SIDX_W          = $clog2(ORDERS_PER_SIDE);
    localparam int SCNT_W          = $clog2(ORDERS_PER_SIDE + 1);
    localparam int SLOT_W          = $clog2(SLOTS);

    // Commands from controller to datapath
    typedef struct packed {
        logic load;       // capture incoming order
        logic scan_clr;   // restart a side scan
        logic scan_step;  // examine one entry
        logic scan_opp;   // scan the side opposite the order
        logic scan_bid;   // side being scanned when not scan_opp (1: bids)
        logic fill;       // apply fill to the best entry found
        logic rest;       // place remainder in free slot
        logic drop;       // flag remainder as dropped
        logic emit_trade;
        logic emit_sum;
        logic save_bid;   // latch scan result as top bid
        logic save_ask;
    } t_cmd;

    typedef struct packed {
        logic scan_done;
        logic match_ok;   // best found and price crosses and qty > 0
        logic qty_zero;
        logic free_found;
    } t_status;
endpackage

@@ sv/lom_ctrl.sv @@
// Controller state machine of the matcher: sequences scans, fills, rest and summary.
// Depends on lom_pkg.
module lom_ctrl import lom_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_status i_st,
    output t_cmd    o_cmd,
    output logic    o_busy
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MSCAN = 7'b0000010,
        S_MDEC  = 7'b0000100,
        S_REST  = 7'b0001000,
        S_BSCAN = 7'b0010000,
        S_ASCAN = 7'b0100000,
        S_SUM   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [SCNT_W-1:0] r_nfill, n_nfill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_nfill <= '0;
        end else begin
            r_state <= n_state;
            r_nfill <= n_nfill;
        end
    end

    // the datapath knows the order's side; match scans just ask for the opposite one
    always_comb begin
        n_state = r_state;
        n_nfill = r_nfill;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_nfill        = '0;
                    n_state        = S_MSCAN;
                end
            end
            S_MSCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_opp  = 1'b1;
                if (i_st.scan_done) n_state = S_MDEC;
            end
            S_MDEC: begin
                if (i_st.match_ok && (r_nfill != SCNT_W'(ORDERS_PER_SIDE))) begin
                    o_cmd.fill       = 1'b1;
                    o_cmd.emit_trade = 1'b1;
                    o_cmd.scan_clr   = 1'b1;
                    n_nfill          = r_nfill + 1'b1;
                    n_state          = S_MSCAN;
                end else begin
                    n_state = S_REST;
                end
            end
            S_REST: begin
                if (!i_st.qty_zero) begin
                    if (i_st.free_found) o_cmd.rest = 1'b1;
                    else                 o_cmd.drop = 1'b1;
                end
                o_cmd.scan_clr = 1'b1;
                n_state        = S_BSCAN;
            end
            S_BSCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_bid  = 1'b1;
                if (i_st.scan_done) begin
                    o_cmd.save_bid = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_ASCAN;
                end
            end
            S_ASCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.scan_bid  = 1'b0;
                if (i_st.scan_done) begin
                    o_cmd.save_ask = 1'b1;
                    n_state        = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.emit_sum = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

@@ sv/lom_datapath.sv @@
// Datapath of the matcher: order book registers, serial best-entry scan,
// free-slot search, fill arithmetic and result registers. Depends on lom_pkg.
module lom_datapath import lom_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [31:0] i_order_id,
    input  logic [15:0] i_limit_price,
    input  logic [31:0] i_order_qty,
    input  logic        i_buy_side,
    output t_status     o_st,
    output logic        o_valid,
    output logic [31:0] o_fill_qty,
    output logic [15:0] o_fill_price,
    output logic [31:0] o_resting_id,
    output logic [31:0] o_aggressor_id,
    output logic [31:0] o_rested_qty,
    output logic        o_book_full,
    output logic [15:0] o_top_bid,
    output logic        o_bid_present,
    output logic [15:0] o_top_ask,
    output logic        o_ask_present,
    output logic        o_last
);
    logic [SLOTS-1:0]      r_valid;
    logic [PRICE_BITS-1:0] r_eprice [SLOTS];
    logic [31:0]           r_eqty   [SLOTS];
    logic [31:0]           r_eid    [SLOTS];
    logic [31:0]           r_earr   [SLOTS];
    logic [31:0]           r_arrival;

    logic [31:0]           r_id, r_qty;
    logic [PRICE_BITS-1:0] r_price;
    logic                  r_buy;

    // scan state
    logic [SCNT_W-1:0]     r_idx;
    logic                  r_rd_go;     // read stage holds an entry to compare
    logic                  r_rd_v;
    logic [SIDX_W-1:0]     r_rd_idx;
    logic [PRICE_BITS-1:0] r_rd_price;
    logic [31:0]           r_rd_arr;
    logic [31:0]           r_rd_qty;
    logic [31:0]           r_rd_id;
    logic                  r_bfound;
    logic [SIDX_W-1:0]     r_bslot;
    logic [PRICE_BITS-1:0] r_bprice;
    logic [31:0]           r_barr;
    logic [31:0]           r_bqty;
    logic [31:0]           r_bid_id;
    logic                  r_ffound;
    logic [SIDX_W-1:0]     r_fslot;

    logic                  r_bid_p, r_ask_p;
    logic [PRICE_BITS-1:0] r_bid_px, r_ask_px;
    logic                  r_full;
    logic [31:0]           r_rested;

    logic                  scan_high;   // scanning bids
    logic                  scan_done;
    logic                  scan_adv;
    logic [SIDX_W-1:0]     cur;
    logic [SLOT_W-1:0]     cur_slot, best_slot, free_slot;
    logic                  better, take, free_hit;
    logic [31:0]           trade;
    logic                  crosses;

    function automatic logic [SLOT_W-1:0] free_slot_of(input logic [SIDX_W-1:0] k);
        free_slot_of = r_buy ? SLOT_W'(k) : SLOT_W'(k) + SLOT_W'(ORDERS_PER_SIDE);
    endfunction

    // match scan examines the opposite side; book scans follow the command
    assign scan_high = i_cmd.scan_opp ? !r_buy : i_cmd.scan_bid;
    assign scan_adv  = i_cmd.scan_step && !i_cmd.scan_clr
                    && (r_idx != SCNT_W'(ORDERS_PER_SIDE));
    // done once every entry is read and the last one compared
    assign scan_done = (r_idx == SCNT_W'(ORDERS_PER_SIDE)) && !r_rd_go;
    assign cur       = r_idx[SIDX_W-1:0];
    assign cur_slot  = scan_high ? SLOT_W'(cur) : SLOT_W'(cur) + SLOT_W'(ORDERS_PER_SIDE);
    assign best_slot = r_buy ? SLOT_W'(r_bslot) + SLOT_W'(ORDERS_PER_SIDE)
                             : SLOT_W'(r_bslot);
    assign free_slot = r_buy ? SLOT_W'(r_fslot) : SLOT_W'(r_fslot) + SLOT_W'(ORDERS_PER_SIDE);
    assign free_hit  = !r_valid[free_slot_of(cur)] && !r_ffound && (scan_high == !r_buy);

    always_comb begin
        if (!r_bfound) begin
            better = 1'b1;
        end else if (r_rd_price != r_bprice) begin
            better = scan_high ? (r_rd_price > r_bprice)
                               : (r_rd_price < r_bprice);
        end else begin
            better = r_rd_arr < r_barr;
        end
    end

    assign take    = r_rd_go && r_rd_v && better;
    assign trade   = (r_qty < r_bqty) ? r_qty : r_bqty;
    assign crosses = r_buy ? !(r_price < r_bprice) : !(r_price > r_bprice);

    assign o_st.scan_done  = scan_done;
    assign o_st.match_ok   = r_bfound && crosses && (r_qty != '0);
    assign o_st.qty_zero   = (r_qty == '0);
    assign o_st.free_found = r_ffound;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_arrival <= '0;
            r_idx     <= '0;
            r_rd_go   <= 1'b0;
            r_bfound  <= 1'b0;
            r_ffound  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit_trade || i_cmd.emit_sum;
            r_rd_go <= scan_adv;
            if (i_cmd.scan_clr) begin
                r_idx    <= '0;
                r_bfound <= 1'b0;
                r_ffound <= 1'b0;
            end else begin
                if (scan_adv) begin
                    r_idx <= r_idx + 1'b1;
                    // free slot of the aggressor's own side, lowest first
                    if (free_hit) r_ffound <= 1'b1;
                end
                if (take) r_bfound <= 1'b1;
            end
            if (i_cmd.fill && (r_bqty == trade)) r_valid[best_slot] <= 1'b0;
            if (i_cmd.rest) begin
                r_valid[free_slot] <= 1'b1;
                r_arrival          <= r_arrival + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_id    <= i_order_id;
            r_price <= i_limit_price[PRICE_BITS-1:0];
            r_qty   <= i_order_qty;
            r_buy   <= i_buy_side;
            r_full  <= 1'b0;
            r_rested <= '0;
        end
        // registered read of the entry under the scan pointer
        if (scan_adv) begin
            r_rd_v     <= r_valid[cur_slot];
            r_rd_idx   <= cur;
            r_rd_price <= r_eprice[cur_slot];
            r_rd_arr   <= r_earr[cur_slot];
            r_rd_qty   <= r_eqty[cur_slot];
            r_rd_id    <= r_eid[cur_slot];
            if (free_hit) r_fslot <= cur;
        end
        if (take) begin
            r_bslot  <= r_rd_idx;
            r_bprice <= r_rd_price;
            r_barr   <= r_rd_arr;
            r_bqty   <= r_rd_qty;
            r_bid_id <= r_rd_id;
        end
        if (i_cmd.fill) begin
            r_qty               <= r_qty - trade;
            r_eqty[best_slot]   <= r_bqty - trade;
        end
        if (i_cmd.rest) begin
            r_eprice[free_slot] <= r_price;
            r_eqty[free_slot]   <= r_qty;
            r_eid[free_slot]    <= r_id;
            r_earr[free_slot]   <= r_arrival;
            r_rested            <= r_qty;
        end
        if (i_cmd.drop) r_full <= 1'b1;
        if (i_cmd.save_bid) begin
            r_bid_p  <= r_bfound;
            r_bid_px <= r_bfound ? r_bprice : '0;
        end
        if (i_cmd.save_ask) begin
            r_ask_p  <= r_bfound;
            r_ask_px <= r_bfound ? r_bprice : '0;
        end
        if (i_cmd.emit_trade) begin
            o_fill_qty     <= trade;
            o_fill_price   <= 16'(r_bprice);
            o_resting_id   <= r_bid_id;
            o_aggressor_id <= r_id;
            o_rested_qty   <= '0;
            o_book_full    <= 1'b0;
            o_top_bid      <= '0;
            o_bid_present  <= 1'b0;
            o_top_ask      <= '0;
            o_ask_present  <= 1'b0;
            o_last         <= 1'b0;
        end
        if (i_cmd.emit_sum) begin
            o_fill_qty     <= '0;
            o_fill_price   <= '0;
            o_resting_id   <= '0;
            o_aggressor_id <= r_id;
            o_rested_qty   <= r_rested;
            o_book_full    <= r_full;
            o_top_bid      <= 16'(r_bid_px);
            o_bid_present  <= r_bid_p;
            o_top_ask      <= 16'(r_ask_px);
            o_ask_present  <= r_ask_p;
            o_last         <= 1'b1;
        end
    end
endmodule

@@ sv/limit_order_matcher_unit.sv @@
// Limit order matcher, top level: controller plus datapath.
// Sequence: a match pass is a 32-entry scan through a registered read plus a decide
// state; f fills take f+1 passes, then come rest, two book scans (bids, then asks)
// and the summary strobe. No new order is accepted until the summary is issued;
// results are strobes on o_valid and the receiver cannot stall. Synchronous
// active-low reset empties the book.
`include "limit_order_matcher_unit_macros.svh"
module limit_order_matcher_unit import lom_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_order_id,
    input  logic [15:0] i_limit_price,
    input  logic [31:0] i_order_qty,
    input  logic        i_buy_side,
    output logic        o_valid,
    output logic [31:0] o_fill_qty,
    output logic [15:0] o_fill_price,
    output logic [31:0] o_resting_id,
    output logic [31:0] o_aggressor_id,
    output logic [31:0] o_rested_qty,
    output logic        o_book_full,
    output logic [15:0] o_top_bid,
    output logic        o_bid_present,
    output logic [15:0] o_top_ask,
    output logic        o_ask_present,
    output logic        o_last
);
    t_cmd    cmd;
    t_status st;

    lom_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    lom_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_order_id     (i_order_id),
        .i_limit_price  (i_limit_price),
        .i_order_qty    (i_order_qty),
        .i_buy_side     (i_buy_side),
        .o_st           (st),
        .o_valid        (o_valid),
        .o_fill_qty     (o_fill_qty),
        .o_fill_price   (o_fill_price),
        .o_resting_id   (o_resting_id),
        .o_aggressor_id (o_aggressor_id),
        .o_rested_qty   (o_rested_qty),
        .o_book_full    (o_book_full),
        .o_top_bid      (o_top_bid),
        .o_bid_present  (o_bid_present),
        .o_top_ask      (o_top_ask),
        .o_ask_present  (o_ask_present),
        .o_last         (o_last)
    );

    `LOM_ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised")
    `LOM_ASSERT_SAME(a_trade_nonzero, i_clk, i_rst_n, o_valid && !o_last, o_fill_qty != 32'd0, "zero-quantity trade")
    `LOM_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, o_valid && o_last, !o_valid, "result after summary")
endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for limit_order_matcher_unit: drives orders, predicts
// the trade and book-summary strobes, and checks each strobe field by field.
// Depends on lom_pkg and the limit_order_matcher_unit RTL.
module tb_top import lom_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] id;
        logic [15:0] price;
        logic [31:0] qty;
        logic        buy;
    } t_order;

    typedef struct packed {
        logic [31:0] fill_qty;
        logic [15:0] fill_price;
        logic [31:0] resting_id;
        logic [31:0] aggressor_id;
        logic [31:0] rested_qty;
        logic        book_full;
        logic [15:0] top_bid;
        logic        bid_present;
        logic [15:0] top_ask;
        logic        ask_present;
        logic        last;
    } t_report;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [31:0] i_order_id = '0;
    logic [15:0] i_limit_price = '0;
    logic [31:0] i_order_qty = '0;
    logic        i_buy_side = 1'b0;
    logic        o_valid;
    logic [31:0] o_fill_qty;
    logic [15:0] o_fill_price;
    logic [31:0] o_resting_id;
    logic [31:0] o_aggressor_id;
    logic [31:0] o_rested_qty;
    logic        o_book_full;
    logic [15:0] o_top_bid;
    logic        o_bid_present;
    logic [15:0] o_top_ask;
    logic        o_ask_present;
    logic        o_last;

    limit_order_matcher_unit u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Shadow book
    logic        bk_valid [SLOTS];
    logic [15:0] bk_price [SLOTS];
    logic [31:0] bk_qty [SLOTS];
    logic [31:0] bk_id [SLOTS];
    logic [31:0] bk_stamp [SLOTS];
    logic [31:0] stamp_ctr;

    t_order  pending_orders[$];
    t_report expected_reports[$];
    int      n_mismatch = 0;
    int      n_reports = 0;
    int      n_trades = 0;
    int      n_full = 0;
    int      n_sent = 0;
    bit      calm = 1'b0;
    bit      all_sent = 1'b0;
    longint  cycle = 0;

    function automatic int top_of_side(bit bids);
        int base;
        int best;
        base = bids ? 0 : ORDERS_PER_SIDE;
        best = -1;
        for (int i = base; i < base + ORDERS_PER_SIDE; i++) begin
            if (!bk_valid[i]) continue;
            if (best < 0) best = i;
            else if (bk_price[i] != bk_price[best]) begin
                if (bids ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]))
                    best = i;
            end else if (bk_stamp[i] < bk_stamp[best]) best = i;
        end
        return best;
    endfunction

    task automatic match_order(input t_order o);
        logic [31:0] remain;
        logic [31:0] t;
        int          e;
        int          slot;
        int          nfill;
        t_report     r;
        remain = o.qty;
        nfill = 0;
        while (remain > 0 && nfill < ORDERS_PER_SIDE) begin
            e = top_of_side(!o.buy);
            if (e < 0) break;
            if (o.buy ? (o.price < bk_price[e]) : (o.price > bk_price[e])) break;
            t = (remain < bk_qty[e]) ? remain : bk_qty[e];
            r = '0;
            r.fill_qty = t;
            r.fill_price = bk_price[e];
            r.resting_id = bk_id[e];
            r.aggressor_id = o.id;
            expected_reports.insert(expected_reports.size(), r);
            nfill++;
            remain -= t;
            bk_qty[e] -= t;
            if (bk_qty[e] == 0) bk_valid[e] = 1'b0;
        end
        r = '0;
        r.aggressor_id = o.id;
        r.last = 1'b1;
        if (remain > 0) begin
            slot = -1;
            for (int i = (o.buy ? 0 : ORDERS_PER_SIDE);
                 i < (o.buy ? 0 : ORDERS_PER_SIDE) + ORDERS_PER_SIDE; i++) begin
                if (!bk_valid[i]) begin
                    slot = i;
                    break;
                end
            end
            if (slot < 0) r.book_full = 1'b1;
            else begin
                bk_valid[slot] = 1'b1;
                bk_price[slot] = o.price;
                bk_qty[slot] = remain;
                bk_id[slot] = o.id;
                bk_stamp[slot] = stamp_ctr;
                stamp_ctr++;
                r.rested_qty = remain;
            end
        end
        e = top_of_side(1'b1);
        if (e >= 0) begin
            r.top_bid = bk_price[e];
            r.bid_present = 1'b1;
        end
        e = top_of_side(1'b0);
        if (e >= 0) begin
            r.top_ask = bk_price[e];
            r.ask_present = 1'b1;
        end
        expected_reports.insert(expected_reports.size(), r);
    endtask

    function automatic t_order mk(logic [31:0] id, logic [15:0] p, logic [31:0] q, logic b);
        t_order o;
        o.id = id;
        o.price = p;
        o.qty = q;
        o.buy = b;
        return o;
    endfunction

    // Driver: hold start until accepted; random idle bursts between orders
    int gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                match_order(pending_orders[0]);
                pending_orders.delete(0);
                n_sent++;
                start <= 1'b0;
                gap = (!calm && $urandom_range(0, 2) == 0) ? int'($urandom_range(1, 14)) : 0;
            end else if (!start) begin
                if (gap > 0) gap--;
                else if (pending_orders.size() > 0) begin
                    i_order_id <= pending_orders[0].id;
                    i_limit_price <= pending_orders[0].price;
                    i_order_qty <= pending_orders[0].qty;
                    i_buy_side <= pending_orders[0].buy;
                    start <= 1'b1;
                end
            end
        end
    end

    // Monitor
    always @(posedge i_clk) begin
        t_report a;
        t_report x;
        cycle++;
        if (i_rst_n && o_valid) begin
            a.fill_qty = o_fill_qty;
            a.fill_price = o_fill_price;
            a.resting_id = o_resting_id;
            a.aggressor_id = o_aggressor_id;
            a.rested_qty = o_rested_qty;
            a.book_full = o_book_full;
            a.top_bid = o_top_bid;
            a.bid_present = o_bid_present;
            a.top_ask = o_top_ask;
            a.ask_present = o_ask_present;
            a.last = o_last;
            n_reports++;
            if (expected_reports.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("ERROR: unexpected transaction aggressor=%h fill=%0d last=%b",
                             a.aggressor_id, a.fill_qty, a.last);
            end else begin
                x = expected_reports[0];
                expected_reports.delete(0);
                if (!x.last) n_trades++;
                if (x.book_full) n_full++;
                if (a !== x) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("ERROR: mismatch exp %p\n       got %p", x, a);
                end
            end
        end
    end

    initial begin
        t_order o;
        int     base_p;
        for (int i = 0; i < SLOTS; i++) bk_valid[i] = 1'b0;
        stamp_ctr = '0;

        // Directed: empty book, zero qty, extremes, sweeps, partial fills, full side
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0001, 16'd100, 32'd0, 1'b1));
        pending_orders.insert(pending_orders.size(),
                              mk(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        pending_orders.insert(pending_orders.size(),
                              mk(32'h0000_0000, 16'h0000, 32'hFFFF_FFFF, 1'b0));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0010, 16'd500, 32'd10, 1'b0));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0011, 16'd500, 32'd20, 1'b0));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0012, 16'd499, 32'd5, 1'b0));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0013, 16'd498, 32'd1, 1'b1));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0014, 16'd500, 32'd12, 1'b1));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0015, 16'd600, 32'd100, 1'b1));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0016, 16'd0, 32'd0, 1'b0));
        pending_orders.insert(pending_orders.size(), mk(32'h0000_0017, 16'd0, 32'd1000, 1'b0));
        // Fill the ask side past capacity, then sweep it all
        for (int i = 0; i < ORDERS_PER_SIDE + 2; i++)
            pending_orders.insert(pending_orders.size(),
                                  mk(32'(32'h100 + i), 16'(700 + i % 3), 32'd1, 1'b0));
        pending_orders.insert(pending_orders.size(),
                              mk(32'h0000_0200, 16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        pending_orders.insert(pending_orders.size(),
                              mk(32'h0000_0201, 16'h0000, 32'hFFFF_FFFF, 1'b0));

        // Random: clustered prices so orders cross often
        for (int i = 0; i < 263; i++) begin
            base_p = 1000;
            o.id = $urandom();
            o.buy = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: o.price = 16'($urandom());
                1: o.price = o.buy ? 16'hFFFF : 16'h0000;
                default: o.price = 16'(base_p + int'($urandom_range(0, 12)) - 6);
            endcase
            case ($urandom_range(0, 9))
                0: o.qty = $urandom();
                1: o.qty = '0;
                2: o.qty = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: o.qty = $urandom_range(1, 50);
            endcase
            pending_orders.insert(pending_orders.size(), o);
            if (i == 220) begin
                wait (pending_orders.size() < 5);
                calm = 1'b1;
            end
        end
        all_sent = 1'b1;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (all_sent && pending_orders.size() == 0 && !start);
        while (expected_reports.size() != 0 && cycle < 2000000) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d orders, %0d trades, %0d dropped remainders, %0d strobes.",
                 n_sent, n_trades, n_full, n_reports);
        if (n_mismatch == 0 && expected_reports.size() == 0)
            $display("*** PASSED ***");
        else begin
            $display("%0d mismatches, %0d results outstanding",
                     n_mismatch, expected_reports.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: fail the run once the cycle counter reaches its limit
    initial begin
        wait (cycle >= 2000000);
        $display("Timeout after %0d cycles", cycle);
        $display("*** FAILED ***");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/lom_pkg.sv
sv/lom_ctrl.sv
sv/lom_datapath.sv
sv/limit_order_matcher_unit.sv
dv/tb_top.sv
